@@ hw/rtl/rppfb_pkg.sv @@
// Package for the rotate, project and plot frame store: sizes, codes and types.
`default_nettype none

package rppfb_pkg;

  localparam int ROW_LEN   = 88;
  localparam int ROWS      = 17;
  localparam int X_CENTER  = 44;
  localparam int Y_CENTER  = 8;
  localparam int FRAC_BITS = 14;

  localparam int CELLS     = ROWS * ROW_LEN;
  localparam int CELL_AW   = $clog2(CELLS);
  localparam int GLYPH_W   = 8;
  localparam int COORD_W   = 6;
  localparam int TRIG_W    = 16;
  localparam int OP_W      = 2;

  localparam int MUL_A_W   = 2 * TRIG_W;
  localparam int MUL_B_W   = 24;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = PROD_W;
  localparam int DIV_SHIFT = 3 * FRAC_BITS;
  localparam int POS_W     = 14;
  localparam int IDX_W     = 22;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;

  localparam logic [GLYPH_W-1:0] DOT_CHAR = 8'd46;

  typedef enum logic [OP_W-1:0] {
    OP_PLOT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_SIN_A = 3'd0,
    REG_COS_A = 3'd1,
    REG_SIN_B = 3'd2,
    REG_COS_B = 3'd3,
    REG_SIN_C = 3'd4,
    REG_COS_C = 3'd5
  } reg_idx_t;

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_CLEAR = 8'b0000_0100,
    ST_READ  = 8'b0000_1000,
    ST_MUL   = 8'b0001_0000,
    ST_ACC   = 8'b0010_0000,
    ST_CONV  = 8'b0100_0000,
    ST_INDEX = 8'b1000_0000
  } state_t;

  // multiplier schedule, one product per step
  typedef enum logic [3:0] {
    MS_Y_SA   = 4'd0,
    MS_Z_CA   = 4'd1,
    MS_Y_CA   = 4'd2,
    MS_Z_SA   = 4'd3,
    MS_X_CB   = 4'd4,
    MS_SB_CC  = 4'd5,
    MS_SB_SC  = 4'd6,
    MS_U_SBCC = 4'd7,
    MS_V_SC   = 4'd8,
    MS_W_CC   = 4'd9,
    MS_V_CC   = 4'd10,
    MS_W_SC   = 4'd11,
    MS_U_SBSC = 4'd12
  } mstep_t;

endpackage

`default_nettype wire

@@ hw/rtl/rotate_project_plot_framebuffer_top.sv @@
// Rotate, project and plot character frame store (17 x 88 cells) with APB config.
`default_nettype none

// Each input beat is one operation, chosen by in_tuser: plot, clear or read.
// A plot rotates the point through one shared 32x24 multiplier and a shared
// accumulator, 13 products in sequence, then truncates, projects and writes
// the glyph if the cell lies in the frame; no new beat is taken until the
// plot is done. A read goes through the frame memory's registered read port.
// A clear writes '.' to one cell per cycle. After reset the same sweep fills
// the store with '.' before the first beat is taken; register writes are
// taken during it. Every beat, also one with the unused code, gives one result
// beat; the result register lets the next beat in while a result waits to be taken.
module rotate_project_plot_framebuffer_top
  import rppfb_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  // tdata: point_x[5:0], point_y[11:6], point_z[17:12], glyph[25:18],
  //        read_index[36:26], zero fill
  input  wire [IN_DATA_W-1:0]    in_tdata,
  // tuser: operation[1:0]
  input  wire [OP_W-1:0]         in_tuser,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // tdata: cell_glyph[7:0], plotted[8], cell_index[19:9], zero fill
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  input  wire                    cfg_psel,
  input  wire                    cfg_penable,
  input  wire                    cfg_pwrite,
  input  wire [CFG_AW-1:0]       cfg_paddr,
  input  wire [CFG_DW-1:0]       cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  // configuration
  logic signed [TRIG_W-1:0] sin_a_r, cos_a_r, sin_b_r, cos_b_r, sin_c_r, cos_c_r;
  reg_idx_t                 cfg_idx;
  logic                     cfg_wr;

  // control
  state_t               state_r, state_nxt;
  mstep_t               step_r;
  logic [CELL_AW-1:0]   clr_cnt_r;
  logic                 in_acc;
  logic                 out_free;

  // captured beat
  op_t                        op_r;
  logic signed [COORD_W-1:0]  pt_x_r, pt_y_r, pt_z_r;
  logic [GLYPH_W-1:0]         glyph_r;
  logic [CELL_AW-1:0]         rd_addr_r;

  // shared multiplier and accumulator
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod_r;
  mstep_t                     prod_step_r;
  logic                       prod_vld_r;
  logic signed [ACC_W-1:0]    acc_base, acc_opnd, acc_sum, prod_shl;
  logic                       acc_sub;
  logic signed [MUL_B_W-1:0]  u_r, v_r, w_r;
  logic signed [MUL_A_W-1:0]  sbcc_r, sbsc_r;
  logic signed [ACC_W-1:0]    acc_row_r, acc_pitch_r;

  // projection
  logic signed [ACC_W-1:0]    row_q, pitch_q;
  logic                       row_adj, pitch_adj;
  logic signed [POS_W-1:0]    row_r, line_r;
  logic signed [IDX_W-1:0]    row_ext, line_ext, idx;
  logic                       idx_ok;
  logic                       plotted_r;
  logic [CELL_AW-1:0]         index_r;

  // frame memory
  logic [GLYPH_W-1:0]         mem [CELLS];
  logic [GLYPH_W-1:0]         rd_data_r;
  logic                       mem_we;
  logic [CELL_AW-1:0]         mem_waddr;
  logic [GLYPH_W-1:0]         mem_wdata;
  logic [GLYPH_W-1:0]         res_glyph;

  logic [OUT_DATA_W-1:0]      out_tdata_r;
  logic                       out_tvalid_r;
  logic                       done_r;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_a_r <= '0;
      cos_a_r <= TRIG_W'(1 << FRAC_BITS);
      sin_b_r <= '0;
      cos_b_r <= TRIG_W'(1 << FRAC_BITS);
      sin_c_r <= '0;
      cos_c_r <= TRIG_W'(1 << FRAC_BITS);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SIN_A: sin_a_r <= cfg_pwdata[TRIG_W-1:0];
        REG_COS_A: cos_a_r <= cfg_pwdata[TRIG_W-1:0];
        REG_SIN_B: sin_b_r <= cfg_pwdata[TRIG_W-1:0];
        REG_COS_B: cos_b_r <= cfg_pwdata[TRIG_W-1:0];
        REG_SIN_C: sin_c_r <= cfg_pwdata[TRIG_W-1:0];
        REG_COS_C: cos_c_r <= cfg_pwdata[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SIN_A: cfg_prdata = {{(CFG_DW-TRIG_W){1'b0}}, sin_a_r};
      REG_COS_A: cfg_prdata = {{(CFG_DW-TRIG_W){1'b0}}, cos_a_r};
      REG_SIN_B: cfg_prdata = {{(CFG_DW-TRIG_W){1'b0}}, sin_b_r};
      REG_COS_B: cfg_prdata = {{(CFG_DW-TRIG_W){1'b0}}, cos_b_r};
      REG_SIN_C: cfg_prdata = {{(CFG_DW-TRIG_W){1'b0}}, sin_c_r};
      REG_COS_C: cfg_prdata = {{(CFG_DW-TRIG_W){1'b0}}, cos_c_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign in_tready = (state_r == ST_IDLE) && !done_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        if (clr_cnt_r == CELL_AW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (op_t'(in_tuser))
            OP_PLOT:  state_nxt = ST_MUL;
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_IDLE;
      ST_MUL: begin
        if (step_r == MS_U_SBSC) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC:   state_nxt = ST_CONV;
      ST_CONV:  state_nxt = ST_INDEX;
      ST_INDEX: state_nxt = ST_IDLE;
      default:  state_nxt = ST_INIT;
    endcase
  end

  // done_r marks a finished beat whose result is not yet in the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      step_r    <= MS_Y_SA;
      clr_cnt_r <= '0;
      done_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_INIT || state_r == ST_CLEAR) begin
        clr_cnt_r <= (clr_cnt_r == CELL_AW'(CELLS - 1)) ? '0 : clr_cnt_r + 1'b1;
      end
      if (in_acc) begin
        step_r <= MS_Y_SA;
      end else if (state_r == ST_MUL) begin
        step_r <= mstep_t'(step_r + 4'd1);
      end
      if (in_acc && op_t'(in_tuser) == OP_NONE) begin
        done_r <= 1'b1;
      end else if (state_r == ST_READ || state_r == ST_INDEX) begin
        done_r <= 1'b1;
      end else if (state_r == ST_CLEAR && clr_cnt_r == CELL_AW'(CELLS - 1)) begin
        done_r <= 1'b1;
      end else if (done_r && out_free) begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= op_t'(in_tuser);
      pt_x_r    <= in_tdata[5:0];
      pt_y_r    <= in_tdata[11:6];
      pt_z_r    <= in_tdata[17:12];
      glyph_r   <= in_tdata[25:18];
      rd_addr_r <= in_tdata[36:26];
    end
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    unique case (step_r)
      MS_Y_SA:   begin mul_a = MUL_A_W'(sin_a_r); mul_b = MUL_B_W'(pt_y_r); end
      MS_Z_CA:   begin mul_a = MUL_A_W'(cos_a_r); mul_b = MUL_B_W'(pt_z_r); end
      MS_Y_CA:   begin mul_a = MUL_A_W'(cos_a_r); mul_b = MUL_B_W'(pt_y_r); end
      MS_Z_SA:   begin mul_a = MUL_A_W'(sin_a_r); mul_b = MUL_B_W'(pt_z_r); end
      MS_X_CB:   begin mul_a = MUL_A_W'(cos_b_r); mul_b = MUL_B_W'(pt_x_r); end
      MS_SB_CC:  begin mul_a = MUL_A_W'(sin_b_r); mul_b = MUL_B_W'(cos_c_r); end
      MS_SB_SC:  begin mul_a = MUL_A_W'(sin_b_r); mul_b = MUL_B_W'(sin_c_r); end
      MS_U_SBCC: begin mul_a = sbcc_r;            mul_b = u_r;               end
      MS_V_SC:   begin mul_a = MUL_A_W'(sin_c_r); mul_b = v_r;               end
      MS_W_CC:   begin mul_a = MUL_A_W'(cos_c_r); mul_b = w_r;               end
      MS_V_CC:   begin mul_a = MUL_A_W'(cos_c_r); mul_b = v_r;               end
      MS_W_SC:   begin mul_a = MUL_A_W'(sin_c_r); mul_b = w_r;               end
      MS_U_SBSC: begin mul_a = sbsc_r;            mul_b = u_r;               end
      default:   begin mul_a = '0;                mul_b = '0;                end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= (state_r == ST_MUL);
    end
    prod_r      <= mul_a * mul_b;
    prod_step_r <= step_r;
  end

  // ---------------- shared accumulator ----------------
  assign prod_shl = {prod_r[PROD_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};

  always_comb begin
    acc_base = '0;
    acc_opnd = prod_r;
    acc_sub  = 1'b0;
    case (prod_step_r)
      MS_Y_SA:   acc_base = ACC_W'(u_r);
      MS_Z_CA:   begin acc_base = ACC_W'(u_r); acc_sub = 1'b1; end
      MS_Y_CA, MS_Z_SA: acc_base = ACC_W'(v_r);
      MS_U_SBCC: acc_base = acc_row_r;
      MS_V_SC, MS_W_CC: begin acc_base = acc_row_r; acc_opnd = prod_shl; end
      MS_V_CC:   begin acc_base = acc_pitch_r; acc_opnd = prod_shl; end
      MS_W_SC:   begin acc_base = acc_pitch_r; acc_opnd = prod_shl; acc_sub = 1'b1; end
      MS_U_SBSC: begin acc_base = acc_pitch_r; acc_sub = 1'b1; end
      default: ;
    endcase
  end

  assign acc_sum = acc_sub ? acc_base - acc_opnd : acc_base + acc_opnd;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      u_r         <= '0;
      v_r         <= '0;
      acc_row_r   <= '0;
      acc_pitch_r <= '0;
    end else if (prod_vld_r) begin
      case (prod_step_r)
        MS_Y_SA, MS_Z_CA: u_r <= acc_sum[MUL_B_W-1:0];
        MS_Y_CA, MS_Z_SA: v_r <= acc_sum[MUL_B_W-1:0];
        MS_X_CB:          w_r <= acc_sum[MUL_B_W-1:0];
        MS_SB_CC:         sbcc_r <= acc_sum[MUL_A_W-1:0];
        MS_SB_SC:         sbsc_r <= acc_sum[MUL_A_W-1:0];
        MS_U_SBCC, MS_V_SC, MS_W_CC: acc_row_r <= acc_sum;
        MS_V_CC, MS_W_SC, MS_U_SBSC: acc_pitch_r <= acc_sum;
        default: ;
      endcase
    end
  end

  // ---------------- truncate toward zero and project ----------------
  assign row_q     = acc_row_r >>> DIV_SHIFT;
  assign row_adj   = acc_row_r[ACC_W-1] && (|acc_row_r[DIV_SHIFT-1:0]);
  assign pitch_q   = acc_pitch_r >>> (DIV_SHIFT + 1);
  assign pitch_adj = acc_pitch_r[ACC_W-1] && (|acc_pitch_r[DIV_SHIFT:0]);

  always_ff @(posedge clk) begin
    if (state_r == ST_CONV) begin
      row_r  <= POS_W'(row_q + {{(ACC_W-1){1'b0}}, row_adj});
      line_r <= POS_W'(pitch_q + {{(ACC_W-1){1'b0}}, pitch_adj} + ACC_W'(Y_CENTER));
    end
  end

  assign row_ext  = IDX_W'(row_r);
  assign line_ext = IDX_W'(line_r);
  assign idx      = row_ext + IDX_W'(X_CENTER) + line_ext * IDX_W'(ROW_LEN);
  assign idx_ok   = !idx[IDX_W-1] && (idx < IDX_W'(CELLS));

  always_ff @(posedge clk) begin
    if (in_acc) begin
      plotted_r <= 1'b0;
      index_r   <= '0;
    end else if (state_r == ST_INDEX) begin
      plotted_r <= idx_ok;
      index_r   <= idx_ok ? idx[CELL_AW-1:0] : '0;
    end
  end

  // ---------------- frame memory ----------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_r;
    mem_wdata = DOT_CHAR;
    if (state_r == ST_INIT || state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == ST_INDEX && idx_ok) begin
      mem_we    = 1'b1;
      mem_waddr = idx[CELL_AW-1:0];
      mem_wdata = glyph_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr_r];
  end

  // ---------------- result register ----------------
  assign res_glyph = (op_r == OP_READ && rd_addr_r < CELL_AW'(CELLS)) ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (done_r && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (done_r && out_free) begin
      out_tdata_r <= {{(OUT_DATA_W-GLYPH_W-1-CELL_AW){1'b0}}, index_r, plotted_r, res_glyph};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

@@ verif/rotate_project_plot_framebuffer_top_test.sv @@
// Self-checking stream test of the rotate, project and plot character frame store.

class frame_tracker;
  typedef struct packed {
    logic [10:0] idx;
    logic        drawn;
    logic [7:0]  glyph;
  } cell_result_t;

  logic [7:0]         cells [0:rppfb_pkg::CELLS-1];
  logic signed [15:0] trig [0:5];
  cell_result_t       due_results [$];
  int errors, n_beats, n_plots, n_drawn, n_reads, n_clears, n_unused, n_checked;
  int last_drawn;

  function new();
    foreach (cells[i]) cells[i] = rppfb_pkg::DOT_CHAR;
    trig[rppfb_pkg::REG_SIN_A] = 16'sd0;
    trig[rppfb_pkg::REG_COS_A] = 16'sd16384;
    trig[rppfb_pkg::REG_SIN_B] = 16'sd0;
    trig[rppfb_pkg::REG_COS_B] = 16'sd16384;
    trig[rppfb_pkg::REG_SIN_C] = 16'sd0;
    trig[rppfb_pkg::REG_COS_C] = 16'sd16384;
    errors     = 0;
    n_beats    = 0;
    n_plots    = 0;
    n_drawn    = 0;
    n_reads    = 0;
    n_clears   = 0;
    n_unused   = 0;
    n_checked  = 0;
    last_drawn = -1;
  endfunction

  function void set_trig(rppfb_pkg::reg_idx_t r, logic [15:0] v);
    trig[r] = v;
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  // model one beat; a plot rotates the point exactly at 42 fraction bits, truncates, projects, writes
  function void note_beat(rppfb_pkg::op_t op, logic [39:0] d);
    cell_result_t res;
    longint x, y, z, sa, ca, sb, cb, sc, cc, one, den, row, pitch, col, line, idx;
    logic [10:0] ri;
    res = '0;
    n_beats++;
    x  = longint'($signed(d[5:0]));
    y  = longint'($signed(d[11:6]));
    z  = longint'($signed(d[17:12]));
    ri = d[36:26];
    case (op)
      rppfb_pkg::OP_PLOT: begin
        n_plots++;
        sa  = longint'(trig[rppfb_pkg::REG_SIN_A]);
        ca  = longint'(trig[rppfb_pkg::REG_COS_A]);
        sb  = longint'(trig[rppfb_pkg::REG_SIN_B]);
        cb  = longint'(trig[rppfb_pkg::REG_COS_B]);
        sc  = longint'(trig[rppfb_pkg::REG_SIN_C]);
        cc  = longint'(trig[rppfb_pkg::REG_COS_C]);
        one = longint'(1) << rppfb_pkg::FRAC_BITS;
        den = longint'(1) << (3 * rppfb_pkg::FRAC_BITS);
        row = y * sa * sb * cc - z * ca * sb * cc
            + (y * ca * sc + z * sa * sc + x * cb * cc) * one;
        pitch = (y * ca * cc + z * sa * cc - x * cb * sc) * one
              - y * sa * sb * sc + z * ca * sb * sc;
        row   = row / den;
        pitch = pitch / den;
        col   = row + rppfb_pkg::X_CENTER;
        line  = pitch / 2 + rppfb_pkg::Y_CENTER;
        idx   = col + line * rppfb_pkg::ROW_LEN;
        if (idx >= 0 && idx < rppfb_pkg::CELLS) begin
          cells[idx] = d[25:18];
          res.drawn  = 1'b1;
          res.idx    = 11'(idx);
          last_drawn = int'(idx);
          n_drawn++;
        end
      end
      rppfb_pkg::OP_CLEAR: begin
        n_clears++;
        foreach (cells[i]) cells[i] = rppfb_pkg::DOT_CHAR;
      end
      rppfb_pkg::OP_READ: begin
        n_reads++;
        if (ri < rppfb_pkg::CELLS) res.glyph = cells[ri];
      end
      default: n_unused++;
    endcase
    due_results.push_back(res);
  endfunction

  function void check_beat(logic [23:0] d);
    cell_result_t want;
    if (due_results.size() == 0) begin
      $error("result beat 0x%06h with no result due", d);
      errors++;
      return;
    end
    want = due_results.pop_front();
    n_checked++;
    if (d[7:0] !== want.glyph) begin
      $error("cell_glyph: expected %0d, got %0d", want.glyph, d[7:0]);
      errors++;
    end
    if (d[8] !== want.drawn) begin
      $error("plotted: expected %0d, got %0d", want.drawn, d[8]);
      errors++;
    end
    if (d[19:9] !== want.idx) begin
      $error("cell_index: expected %0d, got %0d", want.idx, d[19:9]);
      errors++;
    end
    if (d[23:20] !== 4'd0) begin
      $error("tdata fill: expected 0, got %0d", d[23:20]);
      errors++;
    end
  endfunction
endclass

module rotate_project_plot_framebuffer_top_test;
  import rppfb_pkg::*;

  // worst case: every beat a clear plus long random stalls
  localparam int LIMIT_CYCLES = 5_000_000;
  localparam int SEGMENTS     = 6;
  localparam int SEG_BEATS    = 92;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_AW-1:0]     cfg_paddr;
  logic [CFG_DW-1:0]     cfg_pwdata;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  frame_tracker sb;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           cycles;
  int           settings;

  rotate_project_plot_framebuffer_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    while (cycles < LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles", cycles);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata);
  end

  task automatic write_reg(reg_idx_t r, logic [15:0] v);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {r, 2'b00};
    cfg_pwdata  = {{16{v[15]}}, v};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_trig(r, v);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic send_beat(op_t op, int x, int y, int z, int g, int ri);
    logic [IN_DATA_W-1:0] d;
    d = {3'b000, 11'(ri), 8'(g), 6'(z), 6'(y), 6'(x)};
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = d;
    in_tuser  = op;
    do @(posedge clk); while (!in_tready);
    sb.note_beat(op, d);
  endtask

  // hold the sender until every due result is back
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic random_beat();
    int pick, x, y, z, ri;
    op_t op;
    pick = $urandom_range(99);
    if (pick < 68)      op = OP_PLOT;
    else if (pick < 92) op = OP_READ;
    else if (pick < 95) op = OP_CLEAR;
    else                op = OP_NONE;
    if ($urandom_range(99) < 85) begin
      x = int'($urandom_range(32)) - 16;
      y = int'($urandom_range(32)) - 16;
      z = int'($urandom_range(32)) - 16;
    end else begin
      x = $urandom_range(63);
      y = $urandom_range(63);
      z = $urandom_range(63);
    end
    pick = $urandom_range(99);
    if (pick < 45 && sb.last_drawn >= 0) ri = sb.last_drawn;
    else if (pick < 88)                  ri = $urandom_range(CELLS - 1);
    else                                 ri = $urandom_range(2047, CELLS);
    send_beat(op, x, y, z, $urandom_range(255), ri);
  endtask

  initial begin
    logic [15:0] vals [0:5];
    real ang;
    sb            = new();
    cycles        = 0;
    settings      = 1;
    send_idle_pct = 26;
    recv_idle_pct = 52;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = OP_PLOT;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, at the reset rotation (identity)
    send_beat(OP_READ, 0, 0, 0, 0, 0);
    send_beat(OP_READ, 0, 0, 0, 0, CELLS - 1);
    send_beat(OP_READ, 0, 0, 0, 0, CELLS);
    send_beat(OP_READ, -1, -1, -1, 255, 2047);
    send_beat(OP_PLOT, 0, 0, 0, 255, 0);
    send_beat(OP_READ, 0, 0, 0, 0, 748);
    send_beat(OP_PLOT, -16, -16, 0, 65, 2047);
    send_beat(OP_PLOT, 31, 31, 31, 0, 0);
    send_beat(OP_PLOT, -32, -32, -32, 90, 0);
    send_beat(OP_PLOT, 31, 15, -32, 0, 0);
    send_beat(OP_PLOT, -32, 14, 31, 128, 0);
    send_beat(OP_READ, 0, 0, 0, 0, 12 + 15 * ROW_LEN);
    send_beat(OP_PLOT, 16, -17, 16, 1, 0);
    send_beat(OP_READ, 0, 0, 0, 0, 28);
    send_beat(OP_NONE, -1, -1, -1, 255, 2047);
    send_beat(OP_CLEAR, -1, -1, -1, 255, 2047);
    send_beat(OP_READ, 0, 0, 0, 0, 748);
    send_beat(OP_READ, 0, 0, 0, 0, 28);
    send_beat(OP_PLOT, 5, -3, 9, 0, 0);
    send_beat(OP_READ, 0, 0, 0, 0, 49 + 7 * ROW_LEN);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      case (seg)
        1: foreach (vals[i]) vals[i] = (i % 2 == 0) ? 16'sd16384 : 16'sd0;
        3: foreach (vals[i]) vals[i] = -16'sd16384;
        4: foreach (vals[i]) begin
          if ($urandom_range(5) == 0)      vals[i] = 16'h8000;
          else if ($urandom_range(5) == 0) vals[i] = 16'h7fff;
          else                             vals[i] = 16'($urandom);
        end
        default: for (int j = 0; j < 3; j++) begin
          ang = $urandom_range(3599) * 3.14159265358979 / 1800.0;
          vals[2 * j]     = 16'($rtoi($sin(ang) * 16384.0));
          vals[2 * j + 1] = 16'($rtoi($cos(ang) * 16384.0));
        end
      endcase
      write_reg(REG_SIN_A, vals[0]);
      write_reg(REG_COS_A, vals[1]);
      write_reg(REG_SIN_B, vals[2]);
      write_reg(REG_COS_B, vals[3]);
      write_reg(REG_SIN_C, vals[4]);
      write_reg(REG_COS_C, vals[5]);
      settings++;
      case (seg / 2)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < SEG_BEATS; n++) random_beat();
    end

    drain();
    repeat (100) @(posedge clk);
    $display("%0d beats over %0d rotation settings: %0d plots (%0d in frame), %0d reads,",
             sb.n_beats, settings, sb.n_plots, sb.n_drawn, sb.n_reads);
    $display("%0d clears, %0d unused codes; %0d results compared",
             sb.n_clears, sb.n_unused, sb.n_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/rppfb_pkg.sv
hw/rtl/rotate_project_plot_framebuffer_top.sv
verif/rotate_project_plot_framebuffer_top_test.sv
